>>> hdl/triangle_strip_assembler_macros.svh
// assertion macros shared by the triangle assembler modules
`ifndef TRIANGLE_STRIP_ASSEMBLER_MACROS_SVH
`define TRIANGLE_STRIP_ASSEMBLER_MACROS_SVH

// condition and consequence in the same cycle
`define TSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle assembler check failed");

// consequence in the cycle after the condition
`define TSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle assembler check failed");

`endif

>>> hdl/tsa_pkg.sv
// types and constants for the triangle strip assembler
package tsa_pkg;

    localparam int unsigned INDEX_WIDTH = 32;

    typedef logic [INDEX_WIDTH-1:0] index_t;
    typedef logic [1:0]             fill_t;

    localparam index_t RESTART_INDEX = '1;

    localparam fill_t FILL_EMPTY = 2'd0;
    localparam fill_t FILL_TWO   = 2'd2;
    localparam fill_t FILL_FULL  = 2'd3;

    typedef struct packed {
        index_t first;
        index_t second;
        index_t third;
    } triangle_t;

    // result of one request from the assembly logic
    typedef struct packed {
        logic      emit;
        triangle_t corners;
    } asm_result_t;

endpackage

>>> hdl/triangle_strip_assembler.sv
// triangle strip and list assembler with restart marker, top level
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | cfg_write, cfg_data (strip_mode)          | in
//  vertex   | in_valid, in_ready, vertex_index, begin_draw | in
//  triangle | out_valid, out_ready, corner_first/second/third | out
//
// one index per cycle while in_ready is high; a triangle appears in the
// cycle after its index request; in_ready drops only while the single
// result register holds a triangle that out_ready does not take
// reset clears the run and mode; there is no clearing pass
`include "triangle_strip_assembler_macros.svh"

module triangle_strip_assembler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  tsa_pkg::index_t vertex_index,
    input  logic            begin_draw,
    output logic            out_valid,
    input  logic            out_ready,
    output tsa_pkg::index_t corner_first,
    output tsa_pkg::index_t corner_second,
    output tsa_pkg::index_t corner_third
);

    logic                 in_fire;
    tsa_pkg::asm_result_t result;
    tsa_pkg::triangle_t   tri_out;

    assign in_fire = in_valid && in_ready;

    tsa_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .vertex_index (vertex_index),
        .begin_draw   (begin_draw),
        .result       (result)
    );

    tsa_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .result    (result),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .tri_out   (tri_out)
    );

    assign corner_first  = tri_out.first;
    assign corner_second = tri_out.second;
    assign corner_third  = tri_out.third;

    `TSA_ASSERT_NEXT(a_emit_shows, clk, rst_n,
        in_fire && result.emit,
        out_valid && (corner_third == $past(vertex_index)))
    `TSA_ASSERT_NEXT(a_restart_silent, clk, rst_n,
        in_fire && (vertex_index == tsa_pkg::RESTART_INDEX),
        !out_valid)

endmodule

>>> hdl/tsa_core.sv
// run state, mode register and triangle assembly logic
`include "triangle_strip_assembler_macros.svh"

module tsa_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    input  logic                 in_fire,
    input  tsa_pkg::index_t      vertex_index,
    input  logic                 begin_draw,
    output tsa_pkg::asm_result_t result
);

    logic              strip_mode_reg;
    tsa_pkg::index_t   older_reg;
    tsa_pkg::index_t   newer_reg;
    tsa_pkg::fill_t    run_fill_reg;
    logic              run_parity_reg;

    tsa_pkg::index_t   older_next;
    tsa_pkg::index_t   newer_next;
    tsa_pkg::fill_t    run_fill_next;
    logic              run_parity_next;

    tsa_pkg::index_t   cur_older;
    tsa_pkg::index_t   cur_newer;
    tsa_pkg::fill_t    cur_fill;
    logic              cur_parity;
    logic              new_parity;
    logic              is_restart;
    tsa_pkg::fill_t    fill_inc;
    tsa_pkg::index_t   swap_a;
    tsa_pkg::index_t   swap_b;

    always_comb
    begin
        // begin_draw empties the run before this index
        cur_older  = begin_draw ? '0 : older_reg;
        cur_newer  = begin_draw ? '0 : newer_reg;
        cur_fill   = begin_draw ? tsa_pkg::FILL_EMPTY : run_fill_reg;
        cur_parity = begin_draw ? 1'b0 : run_parity_reg;

        is_restart = (vertex_index == tsa_pkg::RESTART_INDEX);
        new_parity = ~cur_parity;
        fill_inc   = (cur_fill == tsa_pkg::FILL_FULL) ? tsa_pkg::FILL_FULL
                                                      : cur_fill + 2'd1;

        // even run length swaps the older pair to keep the winding
        swap_a = new_parity ? cur_older : cur_newer;
        swap_b = new_parity ? cur_newer : cur_older;

        result.emit           = 1'b0;
        result.corners.first  = swap_a;
        result.corners.second = swap_b;
        result.corners.third  = vertex_index;

        older_next      = cur_newer;
        newer_next      = vertex_index;
        run_fill_next   = fill_inc;
        run_parity_next = new_parity;

        if (is_restart)
        begin
            older_next      = '0;
            newer_next      = '0;
            run_fill_next   = tsa_pkg::FILL_EMPTY;
            run_parity_next = 1'b0;
        end
        else if (strip_mode_reg)
        begin
            // degenerate strip triangles are dropped
            result.emit = (cur_fill >= tsa_pkg::FILL_TWO) && (swap_a != swap_b)
                          && (swap_a != vertex_index) && (swap_b != vertex_index);
        end
        else
        begin
            result.corners.first  = cur_older;
            result.corners.second = cur_newer;
            if (cur_fill == tsa_pkg::FILL_TWO)
            begin
                result.emit     = 1'b1;
                older_next      = '0;
                newer_next      = '0;
                run_fill_next   = tsa_pkg::FILL_EMPTY;
                run_parity_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_mode_reg <= 1'b0;
            older_reg      <= '0;
            newer_reg      <= '0;
            run_fill_reg   <= tsa_pkg::FILL_EMPTY;
            run_parity_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                strip_mode_reg <= cfg_data;
            end
            if (in_fire)
            begin
                older_reg      <= older_next;
                newer_reg      <= newer_next;
                run_fill_reg   <= run_fill_next;
                run_parity_reg <= run_parity_next;
            end
        end
    end

    `TSA_ASSERT_NEXT(a_restart_clears, clk, rst_n,
        in_fire && (vertex_index == tsa_pkg::RESTART_INDEX),
        (run_fill_reg == tsa_pkg::FILL_EMPTY) && !run_parity_reg)
    `TSA_ASSERT_NEXT(a_list_emit_clears, clk, rst_n,
        in_fire && result.emit && !strip_mode_reg,
        (run_fill_reg == tsa_pkg::FILL_EMPTY) && (newer_reg == '0))
    `TSA_ASSERT_SAME(a_strip_no_degenerate, clk, rst_n,
        result.emit && strip_mode_reg,
        (result.corners.first != result.corners.second)
        && (result.corners.first != result.corners.third)
        && (result.corners.second != result.corners.third))

endmodule

>>> hdl/tsa_out_reg.sv
// result register between assembly logic and the output channel
module tsa_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  tsa_pkg::asm_result_t result,
    input  logic                 out_ready,
    output logic                 in_ready,
    output logic                 out_valid,
    output tsa_pkg::triangle_t   tri_out
);

    logic               valid_reg;
    logic               valid_next;
    tsa_pkg::triangle_t tri_reg;

    // free slot, or the held triangle leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (in_fire)
        begin
            valid_next = result.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && result.emit)
        begin
            tri_reg <= result.corners;
        end
    end

    assign out_valid = valid_reg;
    assign tri_out   = tri_reg;

endmodule
